/* design/xtcc_pkg.sv */
// Shared types, codes and the sequencer control store for the conflict counter.
package xtcc_pkg;

  localparam int OP_W   = 2;
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 16;
  localparam int RES_W  = 17;
  localparam int WCNT_W = 7;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_POS   = 2'd1;
  localparam logic [OP_W-1:0] OP_TOTAL = 2'd2;

  localparam logic [RES_W-1:0] CNT_MAX = {RES_W{1'b1}};

  // Sequencer step addresses
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] ST_IDLE     = 5'd0;
  localparam logic [STEP_W-1:0] ST_DONE     = 5'd1;
  localparam logic [STEP_W-1:0] ST_T_JINIT  = 5'd2;
  localparam logic [STEP_W-1:0] ST_T_JEND   = 5'd3;
  localparam logic [STEP_W-1:0] ST_T_QLD    = 5'd4;
  localparam logic [STEP_W-1:0] ST_T_AEND   = 5'd5;
  localparam logic [STEP_W-1:0] ST_T_ASKIP  = 5'd6;
  localparam logic [STEP_W-1:0] ST_T_XLD    = 5'd7;
  localparam logic [STEP_W-1:0] ST_T_INNER  = 5'd8;
  localparam logic [STEP_W-1:0] ST_T_ANEXT  = 5'd9;
  localparam logic [STEP_W-1:0] ST_T_JNEXT  = 5'd10;
  localparam logic [STEP_W-1:0] ST_P_INIT   = 5'd11;
  localparam logic [STEP_W-1:0] ST_P_AEND   = 5'd12;
  localparam logic [STEP_W-1:0] ST_P_ASKIP  = 5'd13;
  localparam logic [STEP_W-1:0] ST_P_XLD    = 5'd14;
  localparam logic [STEP_W-1:0] ST_P_INNER  = 5'd15;
  localparam logic [STEP_W-1:0] ST_P_ANEXT  = 5'd16;
  localparam logic [STEP_W-1:0] ST_P_MINIT  = 5'd17;
  localparam logic [STEP_W-1:0] ST_P_JEND   = 5'd18;
  localparam logic [STEP_W-1:0] ST_P_JSKIP  = 5'd19;
  localparam logic [STEP_W-1:0] ST_P_QLD    = 5'd20;
  localparam logic [STEP_W-1:0] ST_P_INNER2 = 5'd21;
  localparam logic [STEP_W-1:0] ST_P_JNEXT  = 5'd22;

  // Jump conditions
  localparam logic [2:0] CND_NONE     = 3'd0;
  localparam logic [2:0] CND_ALWAYS   = 3'd1;
  localparam logic [2:0] CND_J_END    = 3'd2;
  localparam logic [2:0] CND_A_END    = 3'd3;
  localparam logic [2:0] CND_B_END    = 3'd4;
  localparam logic [2:0] CND_A_SKIP   = 3'd5;
  localparam logic [2:0] CND_J_POS    = 3'd6;
  localparam logic [2:0] CND_OUT_FREE = 3'd7;

  // Read address select
  localparam logic [1:0] AS_J = 2'd0;
  localparam logic [1:0] AS_A = 2'd1;
  localparam logic [1:0] AS_B = 2'd2;

  // Operand register loads
  localparam logic [1:0] LD_HOLD = 2'd0;
  localparam logic [1:0] LD_RD   = 2'd1;
  localparam logic [1:0] LD_VAL  = 2'd2;

  // Index counter operations
  localparam logic [1:0] CO_HOLD    = 2'd0;
  localparam logic [1:0] CO_ZERO    = 2'd1;
  localparam logic [1:0] CO_INC     = 2'd2;
  localparam logic [1:0] CO_AFTER_A = 2'd3;

  typedef struct packed {
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
    logic              stay;
    logic [1:0]        addr_sel;
    logic [1:0]        q_op;
    logic [1:0]        x_op;
    logic [1:0]        j_op;
    logic [1:0]        a_op;
    logic [1:0]        b_op;
    logic              issue;
    logic              skip_j;
    logic              skip_p;
    logic              emit;
  } ucode_t;

  typedef struct packed {
    logic j_end;
    logic a_end;
    logic b_end;
    logic a_skip;
    logic j_pos;
    logic out_free;
  } flags_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    unique case (step)
      ST_IDLE: begin
        w.stay = 1'b1;
      end
      ST_DONE: begin
        w.cond = CND_OUT_FREE; w.target = ST_IDLE; w.stay = 1'b1; w.emit = 1'b1;
      end
      // total: every pivot j, every pair a < b of the others
      ST_T_JINIT: begin
        w.j_op = CO_ZERO;
      end
      ST_T_JEND: begin
        w.cond = CND_J_END; w.target = ST_DONE; w.addr_sel = AS_J;
      end
      ST_T_QLD: begin
        w.q_op = LD_RD; w.a_op = CO_ZERO;
      end
      ST_T_AEND: begin
        w.cond = CND_A_END; w.target = ST_T_JNEXT; w.addr_sel = AS_A; w.skip_j = 1'b1;
      end
      ST_T_ASKIP: begin
        w.cond = CND_A_SKIP; w.target = ST_T_ANEXT; w.addr_sel = AS_A; w.skip_j = 1'b1;
      end
      ST_T_XLD: begin
        w.x_op = LD_RD; w.b_op = CO_AFTER_A;
      end
      ST_T_INNER: begin
        w.cond = CND_B_END; w.target = ST_T_ANEXT; w.stay = 1'b1; w.issue = 1'b1;
        w.addr_sel = AS_B; w.skip_j = 1'b1;
      end
      ST_T_ANEXT: begin
        w.cond = CND_ALWAYS; w.target = ST_T_AEND; w.a_op = CO_INC;
      end
      ST_T_JNEXT: begin
        w.cond = CND_ALWAYS; w.target = ST_T_JEND; w.j_op = CO_INC;
      end
      // position: trial value as pivot
      ST_P_INIT: begin
        w.q_op = LD_VAL; w.a_op = CO_ZERO;
      end
      ST_P_AEND: begin
        w.cond = CND_A_END; w.target = ST_P_MINIT; w.addr_sel = AS_A; w.skip_p = 1'b1;
      end
      ST_P_ASKIP: begin
        w.cond = CND_A_SKIP; w.target = ST_P_ANEXT; w.addr_sel = AS_A; w.skip_p = 1'b1;
      end
      ST_P_XLD: begin
        w.x_op = LD_RD; w.b_op = CO_AFTER_A;
      end
      ST_P_INNER: begin
        w.cond = CND_B_END; w.target = ST_P_ANEXT; w.stay = 1'b1; w.issue = 1'b1;
        w.addr_sel = AS_B; w.skip_p = 1'b1;
      end
      ST_P_ANEXT: begin
        w.cond = CND_ALWAYS; w.target = ST_P_AEND; w.a_op = CO_INC;
      end
      // position: trial value as pair member
      ST_P_MINIT: begin
        w.j_op = CO_ZERO; w.x_op = LD_VAL;
      end
      ST_P_JEND: begin
        w.cond = CND_J_END; w.target = ST_DONE; w.addr_sel = AS_J;
      end
      ST_P_JSKIP: begin
        w.cond = CND_J_POS; w.target = ST_P_JNEXT; w.addr_sel = AS_J;
      end
      ST_P_QLD: begin
        w.q_op = LD_RD; w.b_op = CO_ZERO;
      end
      ST_P_INNER2: begin
        w.cond = CND_B_END; w.target = ST_P_JNEXT; w.stay = 1'b1; w.issue = 1'b1;
        w.addr_sel = AS_B; w.skip_j = 1'b1; w.skip_p = 1'b1;
      end
      ST_P_JNEXT: begin
        w.cond = CND_ALWAYS; w.target = ST_P_JEND; w.j_op = CO_INC;
      end
      default: begin
        w.cond = CND_ALWAYS; w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* design/xtcc_if.sv */
// Request and result channel interfaces of the conflict counter.
interface xtcc_in_if;
  logic                         valid;
  logic                         ready;
  logic [xtcc_pkg::OP_W-1:0]    opcode;
  logic [xtcc_pkg::IDX_W-1:0]   word_index;
  logic [xtcc_pkg::VAL_W-1:0]   word_value;

  modport source (output valid, output opcode, output word_index, output word_value,
                  input ready);
  modport sink   (input valid, input opcode, input word_index, input word_value,
                  output ready);
endinterface

interface xtcc_out_if;
  logic                         valid;
  logic                         ready;
  logic [xtcc_pkg::RES_W-1:0]   conflict_count;

  modport source (output valid, output conflict_count, input ready);
  modport sink   (input valid, input conflict_count, output ready);
endinterface

/* design/xtcc_seq.sv */
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module xtcc_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [xtcc_pkg::OP_W-1:0]   start_op,
  input  xtcc_pkg::flags_t            flags,
  output xtcc_pkg::ucode_t            ctrl,
  output logic                        idle,
  output logic                        issue_en
);
  import xtcc_pkg::*;

  logic [STEP_W-1:0] pc_r;
  logic [STEP_W-1:0] pc_nxt;
  logic [STEP_W-1:0] entry;
  logic              take;

  assign ctrl = ucode_rom(pc_r);
  assign idle = (pc_r == ST_IDLE);

  always_comb begin
    unique case (ctrl.cond)
      CND_NONE:     take = 1'b0;
      CND_ALWAYS:   take = 1'b1;
      CND_J_END:    take = flags.j_end;
      CND_A_END:    take = flags.a_end;
      CND_B_END:    take = flags.b_end;
      CND_A_SKIP:   take = flags.a_skip;
      CND_J_POS:    take = flags.j_pos;
      CND_OUT_FREE: take = flags.out_free;
    endcase
  end

  // drop the pair test on the cycle the inner loop exits
  assign issue_en = ctrl.issue && !take;

  always_comb begin
    unique case (start_op)
      OP_POS:   entry = ST_P_INIT;
      OP_TOTAL: entry = ST_T_JINIT;
      default:  entry = ST_DONE;
    endcase
  end

  always_comb begin
    priority if (start) begin
      pc_nxt = entry;
    end else if (take) begin
      pc_nxt = ctrl.target;
    end else if (ctrl.stay) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* design/xor_triple_conflict_counter_core.sv */
// Top level: word store, pair-test datapath and result register of the conflict counter.
//
// One request at a time. A write or an unknown opcode goes straight to the done step.
// A position query skips the queried position when it lies inside the set in use.
// The word store has a single read port, so the datapath runs one pair test per
// cycle while a sequencer steps the pivot and pair indices. The done step waits
// while the output register still holds a result that has not been accepted. A new
// request is taken while the previous result still waits in the output register.
module xor_triple_conflict_counter_core #(
  parameter int MAX_WORDS = 64,
  parameter int WORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  xtcc_in_if.sink                       in_ch,
  xtcc_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [xtcc_pkg::WCNT_W-1:0]   cfg_wdata
);
  import xtcc_pkg::*;

  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam int AW = $clog2(MAX_WORDS);
  localparam int EW = (CW > IDX_W) ? CW : IDX_W;
  localparam int NW = (CW > WCNT_W) ? CW : WCNT_W;

  logic [WORD_BITS-1:0] mem [MAX_WORDS];
  logic [WORD_BITS-1:0] rd_r;
  logic [WORD_BITS-1:0] q_r;
  logic [WORD_BITS-1:0] x_r;
  logic [WORD_BITS-1:0] val_r;
  logic [WORD_BITS-1:0] val_in;
  logic [IDX_W-1:0]     pos_r;
  logic [CW-1:0]        j_r;
  logic [CW-1:0]        a_r;
  logic [CW-1:0]        b_r;
  logic [CW-1:0]        n;
  logic [CW-1:0]        sel;
  logic [AW-1:0]        mem_addr;
  logic [WCNT_W-1:0]    word_count_r;
  logic [RES_W-1:0]     cnt_r;
  logic [RES_W-1:0]     out_cnt_r;
  logic                 out_valid_r;
  logic                 tv_r;
  logic                 start;
  logic                 idle;
  logic                 issue_en;
  logic                 hit;
  logic                 b_ok;
  logic                 idx_ok;
  ucode_t               ctrl;
  flags_t               flags;

  assign start  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = idle;
  assign val_in = WORD_BITS'(in_ch.word_value);
  assign idx_ok = EW'(in_ch.word_index) < EW'(MAX_WORDS);

  assign n = (NW'(word_count_r) > NW'(MAX_WORDS)) ? CW'(MAX_WORDS) : CW'(word_count_r);

  assign flags.j_end    = j_r >= n;
  assign flags.a_end    = a_r >= n;
  assign flags.b_end    = b_r >= n;
  assign flags.a_skip   = (ctrl.skip_j && (a_r == j_r)) ||
                          (ctrl.skip_p && (EW'(a_r) == EW'(pos_r)));
  assign flags.j_pos    = EW'(j_r) == EW'(pos_r);
  assign flags.out_free = !out_valid_r || out_ch.ready;

  assign b_ok = !(ctrl.skip_j && (b_r == j_r)) && !(ctrl.skip_p && (EW'(b_r) == EW'(pos_r)));
  assign hit  = ((x_r ^ q_r) & (rd_r ^ q_r)) == '0;

  xtcc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .start_op (in_ch.opcode),
    .flags    (flags),
    .ctrl     (ctrl),
    .idle     (idle),
    .issue_en (issue_en)
  );

  always_comb begin
    unique case (ctrl.addr_sel)
      AS_J:    sel = j_r;
      AS_A:    sel = a_r;
      default: sel = b_r;
    endcase
  end
  assign mem_addr = sel[AW-1:0];

  always_ff @(posedge clk) begin
    if (start && (in_ch.opcode == OP_WRITE) && idx_ok) begin
      mem[AW'(in_ch.word_index)] <= val_in;
    end
    rd_r <= mem[mem_addr];
  end

  // index counters and operand registers
  always_ff @(posedge clk) begin
    if (start) begin
      pos_r <= in_ch.word_index;
      val_r <= val_in;
    end
    unique case (ctrl.j_op)
      CO_ZERO: j_r <= '0;
      CO_INC:  j_r <= j_r + CW'(1);
      default: j_r <= j_r;
    endcase
    unique case (ctrl.a_op)
      CO_ZERO: a_r <= '0;
      CO_INC:  a_r <= a_r + CW'(1);
      default: a_r <= a_r;
    endcase
    if (issue_en) begin
      b_r <= b_r + CW'(1);
    end else begin
      unique case (ctrl.b_op)
        CO_ZERO:    b_r <= '0;
        CO_AFTER_A: b_r <= a_r + CW'(1);
        default:    b_r <= b_r;
      endcase
    end
    unique case (ctrl.q_op)
      LD_RD:   q_r <= rd_r;
      LD_VAL:  q_r <= val_r;
      default: q_r <= q_r;
    endcase
    unique case (ctrl.x_op)
      LD_RD:   x_r <= rd_r;
      LD_VAL:  x_r <= val_r;
      default: x_r <= x_r;
    endcase
    if (start) begin
      cnt_r <= '0;
    end else if (tv_r && hit && (cnt_r != CNT_MAX)) begin
      cnt_r <= cnt_r + RES_W'(1);
    end
    if (ctrl.emit && flags.out_free) begin
      out_cnt_r <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r <= '0;
      out_valid_r  <= 1'b0;
      tv_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        word_count_r <= cfg_wdata;
      end
      // test the word read this cycle on the next one
      tv_r <= issue_en && b_ok;
      if (ctrl.emit && flags.out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.conflict_count = out_cnt_r;

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.emit && flags.out_free))
    else $error("result loaded outside the done step");

  a_write_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && (in_ch.opcode == OP_WRITE)) |=> (cnt_r == '0))
    else $error("write request left a nonzero count");

  a_no_test_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !tv_r)
    else $error("pair test pending while accepting a request");

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    issue_en |-> (b_r < n))
    else $error("pair test issued beyond the words in use");

endmodule
